>>> design/trg_pkg.sv
package trg_pkg;

    localparam int unsigned POLL_INTERVAL_MS = 1000;
    localparam int unsigned HOT_FALLBACK_MC  = 1000;
    localparam int unsigned EASE_NUM         = 22282;

    localparam int unsigned RATE_W  = 16;
    localparam int unsigned TEMP_W  = 18;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TIN_W   = 19;
    localparam int unsigned CFG_W   = 18;
    localparam int unsigned CIDX_W  = 2;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [RATE_W-1:0] RATE_COOL_RST = 16'd15360;
    localparam logic [RATE_W-1:0] RATE_HOT_RST  = 16'd3072;
    localparam logic [TEMP_W-1:0] WARM_RST      = 18'd65000;
    localparam logic [TEMP_W-1:0] HOT_RST       = 18'd78000;

    // quotient bits of the Q0.16 fraction, one per divider step
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CIDX_W-1:0] REG_RATE_COOL = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RATE_HOT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WARM      = 2'd2;
    localparam logic [CIDX_W-1:0] REG_HOT       = 2'd3;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic span;
        logic tgt;
        logic ease;
        logic commit;
    } trg_cmd_t;

    typedef struct packed {
        logic poll;
        logic absent;
        logic mid;
        logic out_free;
    } trg_sts_t;

endpackage

>>> design/trg_ctrl.sv
module trg_ctrl
    import trg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  trg_sts_t sts,
    output trg_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_SPAN   = 7'b0001000,
        S_TGT    = 7'b0010000,
        S_EASE   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } trg_state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    trg_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                if (!sts.poll || sts.absent)
                    state_next = S_COMMIT;
                else if (sts.mid)
                    state_next = S_DIV;
                else
                    state_next = S_EASE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.span   = 1'b1;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.tgt    = 1'b1;
                state_next = S_EASE;
            end
            S_EASE:
            begin
                cmd.ease   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/trg_dp.sv
module trg_dp
    import trg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tuser,
    input  trg_cmd_t               cmd,
    output trg_sts_t               sts
);

    logic [RATE_W-1:0] cool_reg, hot_rate_reg;
    logic [TEMP_W-1:0] warm_reg, hot_pt_reg;

    logic [TIME_W-1:0] last_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TEMP_W-1:0] trec_reg;

    logic [TIME_W-1:0]        now_reg;
    logic signed [TIN_W-1:0]  temp_reg;
    logic                     poll_reg, absent_reg;

    logic [TIN_W:0]           rem_reg;
    logic [TIN_W-1:0]         den_reg;
    logic [DIV_STEPS-1:0]     quo_reg;
    logic signed [33:0]       span_prod_reg;
    logic [RATE_W-1:0]        target_reg;
    logic signed [32:0]       ease_prod_reg;

    logic                     out_valid_reg;
    logic [RATE_W-1:0]        out_rate_reg;
    logic [TEMP_W-1:0]        out_temp_reg;
    logic                     out_polled_reg;

    logic [TEMP_W-1:0]        tu;
    logic [TIN_W-1:0]         hot_eff;
    logic [TIME_W-1:0]        elapsed;
    logic                     poll_hit, absent, cold, hot_hit;
    logic [TIN_W:0]           shifted;
    logic signed [RATE_W:0]   span;
    logic signed [RATE_W+1:0] tgt_sum;
    logic signed [RATE_W:0]   gap;
    logic [RATE_W-1:0]        rate_new;
    logic [TEMP_W-1:0]        trec_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_reg     <= RATE_COOL_RST;
            hot_rate_reg <= RATE_HOT_RST;
            warm_reg     <= WARM_RST;
            hot_pt_reg   <= HOT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATE_COOL: cool_reg     <= cfg_data[RATE_W-1:0];
                REG_RATE_HOT:  hot_rate_reg <= cfg_data[RATE_W-1:0];
                REG_WARM:      warm_reg     <= cfg_data[TEMP_W-1:0];
                REG_HOT:       hot_pt_reg   <= cfg_data[TEMP_W-1:0];
                default:       ;
            endcase
        end
    end

    assign tu      = temp_reg[TEMP_W-1:0];
    assign elapsed = now_reg - last_reg;
    assign poll_hit = (last_reg == '0) || (elapsed >= TIME_W'(POLL_INTERVAL_MS));
    assign absent  = temp_reg[TIN_W-1] || (temp_reg == '0);
    assign hot_eff = (hot_pt_reg > warm_reg) ? {1'b0, hot_pt_reg}
                                             : {1'b0, warm_reg} + TIN_W'(HOT_FALLBACK_MC);
    assign cold    = (tu <= warm_reg);
    assign hot_hit = ({1'b0, tu} >= hot_eff);

    assign sts.poll     = poll_hit;
    assign sts.absent   = absent;
    assign sts.mid      = !cold && !hot_hit;
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    // remainder stays below the divisor, so one spare bit covers the shift
    assign shifted = {rem_reg[TIN_W-1:0], 1'b0};
    assign span    = $signed({1'b0, hot_rate_reg}) - $signed({1'b0, cool_reg});
    assign tgt_sum = $signed({2'b00, cool_reg}) + span_prod_reg[33:16];
    assign gap     = $signed({1'b0, target_reg}) - $signed({1'b0, rate_reg});

    always_comb
    begin
        rate_new = rate_reg;
        trec_new = trec_reg;
        if (poll_reg)
        begin
            if (absent_reg)
            begin
                rate_new = cool_reg;
                trec_new = '0;
            end
            else
            begin
                // floor shift of the eased gap, added modulo 2^16
                rate_new = rate_reg + ease_prod_reg[RATE_W+15:16];
                trec_new = tu;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= s_axis_tdata[TIME_W-1:0];
            temp_reg <= s_axis_tdata[TIME_W+TIN_W-1:TIME_W];
        end
        if (cmd.eval)
        begin
            poll_reg   <= poll_hit;
            absent_reg <= absent;
            rem_reg    <= {2'b00, tu} - {2'b00, warm_reg};
            den_reg    <= hot_eff - {1'b0, warm_reg};
            quo_reg    <= '0;
            target_reg <= cold ? cool_reg : hot_rate_reg;
        end
        if (cmd.div_step)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= shifted - {1'b0, den_reg};
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.span)
            span_prod_reg <= span * $signed({1'b0, quo_reg});
        if (cmd.tgt)
            target_reg <= tgt_sum[RATE_W-1:0];
        if (cmd.ease)
            ease_prod_reg <= gap * $signed({1'b0, 15'(EASE_NUM)});
        if (cmd.commit)
        begin
            out_rate_reg   <= rate_new;
            out_temp_reg   <= trec_new;
            out_polled_reg <= poll_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            rate_reg      <= RATE_COOL_RST;
            trec_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (poll_reg)
                    last_reg <= now_reg;
                rate_reg      <= rate_new;
                trec_reg      <= trec_new;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RATE_W - TEMP_W){1'b0}}, out_temp_reg, out_rate_reg};
    assign m_axis_tuser  = out_polled_reg;

endmodule

>>> design/thermal_rate_governor.sv
// Thermal rate governor.
// Input stream s_axis: one request per poll attempt, tdata carries a wrapping
// millisecond timestamp and a signed millidegree temperature. A request is
// taken as a poll when no poll has happened yet or 1000 ms have elapsed; a
// temperature at or below zero clears the recorded value and snaps the rate to
// the cool rate, otherwise the rate eases toward a target interpolated between
// the warm and hot points.
// Output stream m_axis: exactly one result per request, with the Q8.8 rate and
// the recorded temperature in tdata and the poll flag in tuser.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 cool rate,
// 1 hot rate, 2 warm point, 3 hot point) in the same cycle; write only while idle.
// An interpolated temperature passes the evaluate state, the serial divider that
// forms the Q0.16 fraction, then span, target, ease and commit; one outside the
// band goes from evaluate to ease and commit, and an ignored or absent one from
// evaluate to commit. Only one request is in flight at a time.
// Reset restores the register defaults, the rate to the reset cool rate and
// clears the poll history. A stalled result waits in the output register; the
// block accepts the next request meanwhile and holds its result until freed.
module thermal_rate_governor
    import trg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // now_ms[31:0], temp_mc[50:32], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // rate_now[15:0], temp_seen_mc[33:16], pad
    output logic                  m_axis_tuser    // polled
);

    trg_cmd_t cmd;
    trg_sts_t sts;

    trg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    trg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

>>> design/trg_checker.sv
module trg_checker
    import trg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // a result is never produced in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // a new result only comes from a request in flight
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without request in flight");

endmodule

bind thermal_rate_governor trg_checker u_trg_checker (.*);
